@@ rtl/idxh_pkg.sv @@
package idxh_pkg;

	// Command codes carried by a request.
	localparam logic [2:0] CMD_INC    = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_READD  = 3'd3;
	localparam logic [2:0] CMD_DIVIDE = 3'd4;
	localparam logic [2:0] CMD_QUERY  = 3'd5;
	localparam logic [2:0] CMD_PEEK   = 3'd6;

	// Status codes returned with every response.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_PRESENT = 3'd3;
	localparam logic [2:0] ST_ZERODIV = 3'd4;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_FETCH,
		S_KEYVAL,
		S_REM,
		S_REM2,
		S_READD,
		S_READD2,
		S_UP_RD,
		S_UP_CMP,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_PLACE,
		S_DIV_RD,
		S_DIV_LD,
		S_DIV_RUN,
		S_DIV_WR,
		S_DONE
	} state_t;

endpackage

@@ rtl/idxh_req_if.sv @@
interface idxh_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [7:0]  key;
	logic [31:0] amount;
	logic [31:0] divisor;

	modport source (output valid, cmd, key, amount, divisor, input ready);
	modport sink (input valid, cmd, key, amount, divisor, output ready);
endinterface

@@ rtl/idxh_rsp_if.sv @@
interface idxh_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  key_out;
	logic [31:0] value_out;
	logic        present;
	logic [8:0]  heap_size;

	modport source (output valid, status, key_out, value_out, present, heap_size, input ready);
	modport sink (input valid, status, key_out, value_out, present, heap_size, output ready);
endinterface

@@ rtl/idxh_ram.sv @@
module idxh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; a write to the same entry in the same cycle is passed through.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/indexed_max_heap.sv @@
// Indexed binary max-heap over NUM_KEYS keys, each with an unsigned Q16.16 value.
// Requests enter on req (valid/ready): command, key, amount and divisor.
// Every request gives exactly one response on rsp (valid/ready): status, key,
// value, presence and the heap size after the command.
// Requests are handled one at a time by a sequencer around two single-port-write
// RAMs: one holds {key, value} by heap position, the other the position of each key.
// Increment and readd sift the key up; remove and pop sift the former last entry
// down. Divide-all visits every position through a bit-serial divider. After
// reset the block loads identity order and zero values into the RAMs, with
// req.ready low; then all keys are present.
// A finished response waits in the output register while the next request is
// accepted and processed; if rsp.ready stays low, the sequencer holds the next
// response and stops taking requests until the output register frees up.
module indexed_max_heap #(
	parameter int NUM_KEYS   = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	idxh_req_if.sink   req,
	idxh_rsp_if.source rsp
);

	localparam int PW = $clog2(NUM_KEYS);
	localparam int CW = PW + 1;
	localparam int XW = PW + 2;
	localparam int VB = VALUE_BITS;
	localparam int SW = ((VB > 32) ? VB : 32) + 1;
	localparam int NW = $clog2(VB + 1);
	localparam int HW = PW + VB;
	localparam logic [VB-1:0] VMASK = {VB{1'b1}};
	localparam logic [PW-1:0] LAST = PW'(NUM_KEYS - 1);

	idxh_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [PW-1:0] idx_q;
	logic          out_valid_q;

	logic [2:0]    cmd_q;
	logic [7:0]    kin_q;
	logic          kok_q;
	logic [PW-1:0] key_q;
	logic [31:0]   amt_q;
	logic [31:0]   div_q;
	logic [PW-1:0] pos_q;
	logic [VB-1:0] node_v_q;
	logic [PW-1:0] ch_k_q;
	logic [VB-1:0] ch_v_q;
	logic [PW-1:0] ch_p_q;
	logic          rflag_q;
	logic [VB-1:0] dq_q;
	logic [31:0]   dr_q;
	logic [PW-1:0] dk_q;
	logic [NW-1:0] dn_q;

	logic [2:0]  res_status_q;
	logic [7:0]  res_key_q;
	logic [31:0] res_value_q;
	logic        res_pres_q;

	logic [2:0]  out_status_q;
	logic [7:0]  out_key_q;
	logic [31:0] out_value_q;
	logic        out_pres_q;
	logic [8:0]  out_size_q;

	// RAM ports.
	logic          h_we, p_we;
	logic [PW-1:0] h_waddr, h_raddr, p_waddr, p_raddr;
	logic [HW-1:0] h_wdata, h_rdata;
	logic [PW-1:0] p_wdata, p_rdata;

	idxh_ram #(.WIDTH(HW), .DEPTH(NUM_KEYS)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	idxh_ram #(.WIDTH(PW), .DEPTH(NUM_KEYS)) u_pos_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// Helper values.
	logic [PW-1:0] h_rk;
	logic [VB-1:0] h_rv;
	logic          accept, load_out, here;
	logic [SW-1:0] inc_sum;
	logic [VB-1:0] inc_sat;
	logic [PW-1:0] parent;
	logic [XW-1:0] lpos, rpos;
	logic          use_r, stop_up, stop_dn;
	logic [VB-1:0] cv;
	logic [PW-1:0] ck, cp;
	logic [32:0]   div_sh, div_tr;
	logic          div_ge;

	assign h_rk = h_rdata[HW-1:VB];
	assign h_rv = h_rdata[VB-1:0];
	assign accept = req.valid && req.ready;
	assign load_out = (state_q == idxh_pkg::S_DONE) && (!out_valid_q || rsp.ready);
	assign here = CW'(pos_q) < cnt_q;

	// Saturating increment.
	assign inc_sum = SW'(h_rv) + SW'(amt_q);
	assign inc_sat = (inc_sum > SW'(VMASK)) ? VMASK : inc_sum[VB-1:0];

	// Tree navigation.
	assign parent = PW'((idx_q - 1'b1) >> 1);
	assign lpos = XW'({idx_q, 1'b1});
	assign rpos = lpos + 1'b1;
	assign stop_up = h_rv >= node_v_q;

	// Larger child; the right one wins only if strictly greater.
	assign use_r = rflag_q && (h_rv > ch_v_q);
	assign cv = use_r ? h_rv : ch_v_q;
	assign ck = use_r ? h_rk : ch_k_q;
	assign cp = use_r ? PW'(ch_p_q + 1'b1) : ch_p_q;
	assign stop_dn = node_v_q >= cv;

	// One restoring division step.
	assign div_sh = {dr_q, dq_q[VB-1]};
	assign div_tr = div_sh - {1'b0, div_q};
	assign div_ge = !div_tr[32];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idxh_pkg::S_INIT: begin
				if (idx_q == LAST) state_d = idxh_pkg::S_IDLE;
			end
			idxh_pkg::S_IDLE: begin
				if (accept) state_d = idxh_pkg::S_FETCH;
			end
			idxh_pkg::S_FETCH: begin
				case (cmd_q)
					idxh_pkg::CMD_INC, idxh_pkg::CMD_REMOVE, idxh_pkg::CMD_READD,
					idxh_pkg::CMD_QUERY: begin
						state_d = kok_q ? idxh_pkg::S_KEYVAL : idxh_pkg::S_DONE;
					end
					idxh_pkg::CMD_POP: begin
						state_d = (cnt_q == '0) ? idxh_pkg::S_DONE : idxh_pkg::S_REM;
					end
					idxh_pkg::CMD_DIVIDE: begin
						state_d = (div_q == '0) ? idxh_pkg::S_DONE : idxh_pkg::S_DIV_RD;
					end
					default: state_d = idxh_pkg::S_DONE;
				endcase
			end
			idxh_pkg::S_KEYVAL: begin
				case (cmd_q)
					idxh_pkg::CMD_INC:    state_d = here ? idxh_pkg::S_UP_RD : idxh_pkg::S_DONE;
					idxh_pkg::CMD_REMOVE: state_d = here ? idxh_pkg::S_REM : idxh_pkg::S_DONE;
					idxh_pkg::CMD_READD:  state_d = here ? idxh_pkg::S_DONE : idxh_pkg::S_READD;
					default:              state_d = idxh_pkg::S_DONE;
				endcase
			end
			idxh_pkg::S_REM: state_d = idxh_pkg::S_REM2;
			idxh_pkg::S_REM2: begin
				state_d = (CW'(pos_q) == cnt_q - 1'b1) ? idxh_pkg::S_DONE : idxh_pkg::S_DN_L;
			end
			idxh_pkg::S_READD:  state_d = idxh_pkg::S_READD2;
			idxh_pkg::S_READD2: state_d = idxh_pkg::S_UP_RD;
			idxh_pkg::S_UP_RD: begin
				state_d = (idx_q == '0) ? idxh_pkg::S_PLACE : idxh_pkg::S_UP_CMP;
			end
			idxh_pkg::S_UP_CMP: begin
				state_d = stop_up ? idxh_pkg::S_PLACE : idxh_pkg::S_UP_RD;
			end
			idxh_pkg::S_DN_L: begin
				state_d = (lpos >= XW'(cnt_q)) ? idxh_pkg::S_PLACE : idxh_pkg::S_DN_R;
			end
			idxh_pkg::S_DN_R: state_d = idxh_pkg::S_DN_CMP;
			idxh_pkg::S_DN_CMP: begin
				state_d = stop_dn ? idxh_pkg::S_PLACE : idxh_pkg::S_DN_L;
			end
			idxh_pkg::S_PLACE:  state_d = idxh_pkg::S_DONE;
			idxh_pkg::S_DIV_RD: state_d = idxh_pkg::S_DIV_LD;
			idxh_pkg::S_DIV_LD: state_d = idxh_pkg::S_DIV_RUN;
			idxh_pkg::S_DIV_RUN: begin
				if (dn_q == NW'(1)) state_d = idxh_pkg::S_DIV_WR;
			end
			idxh_pkg::S_DIV_WR: begin
				state_d = (idx_q == LAST) ? idxh_pkg::S_DONE : idxh_pkg::S_DIV_RD;
			end
			idxh_pkg::S_DONE: begin
				if (load_out) state_d = idxh_pkg::S_IDLE;
			end
			default: state_d = idxh_pkg::S_IDLE;
		endcase
	end

	// Memory accesses and handshake outputs.
	always_comb begin
		h_we = 1'b0;
		h_waddr = idx_q;
		h_wdata = {key_q, node_v_q};
		p_we = 1'b0;
		p_waddr = key_q;
		p_wdata = idx_q;
		h_raddr = '0;
		p_raddr = PW'(req.key);
		req.ready = (state_q == idxh_pkg::S_IDLE);
		unique case (state_q)
			idxh_pkg::S_INIT: begin
				h_we = 1'b1;
				h_wdata = {idx_q, {VB{1'b0}}};
				p_we = 1'b1;
				p_waddr = idx_q;
			end
			idxh_pkg::S_FETCH: h_raddr = p_rdata;
			idxh_pkg::S_KEYVAL: begin
				if (cmd_q == idxh_pkg::CMD_INC && !here) begin
					h_we = 1'b1;
					h_waddr = pos_q;
					h_wdata = {key_q, inc_sat};
				end
			end
			idxh_pkg::S_REM: h_raddr = PW'(cnt_q - 1'b1);
			idxh_pkg::S_REM2: begin
				h_we = 1'b1;
				h_waddr = PW'(cnt_q - 1'b1);
				p_we = 1'b1;
				p_wdata = PW'(cnt_q - 1'b1);
			end
			idxh_pkg::S_READD: h_raddr = PW'(cnt_q);
			idxh_pkg::S_READD2: begin
				h_we = 1'b1;
				h_waddr = pos_q;
				h_wdata = h_rdata;
				p_we = 1'b1;
				p_waddr = h_rk;
				p_wdata = pos_q;
			end
			idxh_pkg::S_UP_RD: h_raddr = parent;
			idxh_pkg::S_UP_CMP: begin
				if (!stop_up) begin
					h_we = 1'b1;
					h_wdata = h_rdata;
					p_we = 1'b1;
					p_waddr = h_rk;
				end
			end
			idxh_pkg::S_DN_L: h_raddr = PW'(lpos);
			idxh_pkg::S_DN_R: h_raddr = PW'(rpos);
			idxh_pkg::S_DN_CMP: begin
				if (!stop_dn) begin
					h_we = 1'b1;
					h_wdata = {ck, cv};
					p_we = 1'b1;
					p_waddr = ck;
				end
			end
			idxh_pkg::S_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			idxh_pkg::S_DIV_RD: h_raddr = idx_q;
			idxh_pkg::S_DIV_WR: begin
				h_we = 1'b1;
				h_wdata = {dk_q, dq_q};
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idxh_pkg::S_INIT;
			cnt_q <= CW'(NUM_KEYS);
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				idxh_pkg::S_INIT:     idx_q <= idx_q + 1'b1;
				idxh_pkg::S_FETCH:    idx_q <= '0;
				idxh_pkg::S_KEYVAL:   idx_q <= pos_q;
				idxh_pkg::S_REM2: begin
					cnt_q <= cnt_q - 1'b1;
					idx_q <= pos_q;
				end
				idxh_pkg::S_READD2: begin
					cnt_q <= cnt_q + 1'b1;
					idx_q <= PW'(cnt_q);
				end
				idxh_pkg::S_UP_CMP: begin
					if (!stop_up) idx_q <= parent;
				end
				idxh_pkg::S_DN_CMP: begin
					if (!stop_dn) idx_q <= cp;
				end
				idxh_pkg::S_DIV_WR:   idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Request, node and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			idxh_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q <= req.cmd;
					kin_q <= req.key;
					kok_q <= {24'd0, req.key} < 32'(NUM_KEYS);
					key_q <= PW'(req.key);
					amt_q <= req.amount;
					div_q <= req.divisor;
				end
			end
			idxh_pkg::S_FETCH: begin
				pos_q <= p_rdata;
				res_status_q <= idxh_pkg::ST_OK;
				res_key_q <= '0;
				res_value_q <= '0;
				res_pres_q <= 1'b0;
				case (cmd_q)
					idxh_pkg::CMD_INC, idxh_pkg::CMD_REMOVE, idxh_pkg::CMD_READD,
					idxh_pkg::CMD_QUERY: begin
						res_key_q <= kin_q;
						if (!kok_q) res_status_q <= idxh_pkg::ST_ABSENT;
					end
					idxh_pkg::CMD_POP, idxh_pkg::CMD_PEEK: begin
						if (cnt_q == '0) begin
							res_status_q <= idxh_pkg::ST_EMPTY;
						end else begin
							res_key_q <= 8'(h_rk);
							res_value_q <= 32'(h_rv);
							res_pres_q <= (cmd_q == idxh_pkg::CMD_PEEK);
							key_q <= h_rk;
							node_v_q <= h_rv;
							pos_q <= '0;
						end
					end
					idxh_pkg::CMD_DIVIDE: begin
						if (div_q == '0) res_status_q <= idxh_pkg::ST_ZERODIV;
					end
					default: ;
				endcase
			end
			idxh_pkg::S_KEYVAL: begin
				res_pres_q <= here;
				res_value_q <= 32'(h_rv);
				node_v_q <= h_rv;
				case (cmd_q)
					idxh_pkg::CMD_INC: begin
						node_v_q <= inc_sat;
						res_value_q <= 32'(inc_sat);
					end
					idxh_pkg::CMD_REMOVE: begin
						res_pres_q <= 1'b0;
						if (!here) res_status_q <= idxh_pkg::ST_ABSENT;
					end
					idxh_pkg::CMD_READD: begin
						res_pres_q <= 1'b1;
						if (here) res_status_q <= idxh_pkg::ST_PRESENT;
					end
					default: ;
				endcase
			end
			idxh_pkg::S_REM2: begin
				// The former last entry becomes the node that sifts down.
				key_q <= h_rk;
				node_v_q <= h_rv;
			end
			idxh_pkg::S_DN_R: begin
				ch_k_q <= h_rk;
				ch_v_q <= h_rv;
				ch_p_q <= PW'(lpos);
				rflag_q <= rpos < XW'(cnt_q);
			end
			idxh_pkg::S_DIV_LD: begin
				dq_q <= h_rv;
				dr_q <= '0;
				dk_q <= h_rk;
				dn_q <= NW'(VB);
			end
			idxh_pkg::S_DIV_RUN: begin
				dr_q <= div_ge ? div_tr[31:0] : div_sh[31:0];
				dq_q <= {dq_q[VB-2:0], div_ge};
				dn_q <= dn_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_key_q <= res_key_q;
			out_value_q <= res_value_q;
			out_pres_q <= res_pres_q;
			out_size_q <= 9'(cnt_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.key_out = out_key_q;
	assign rsp.value_out = out_value_q;
	assign rsp.present = out_pres_q;
	assign rsp.heap_size = out_size_q;

	// The heap never holds more keys than exist.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_KEYS))
		else $error("heap count exceeds the number of keys");

	// Nothing is written to either RAM while waiting for a request.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idxh_pkg::S_IDLE) |-> (!h_we && !p_we))
		else $error("RAM write while idle");

	// The divider only runs with a nonzero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idxh_pkg::S_DIV_RUN) |-> (div_q != '0))
		else $error("division by zero started");

	// A child considered in sift-down lies inside the heap.
	a_child_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idxh_pkg::S_DN_CMP) |-> (CW'(ch_p_q) < cnt_q))
		else $error("sift-down child outside the heap");

	// A response is only loaded when the output register is free or being drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (rsp.valid && $stable(out_key_q)))
		else $error("pending response overwritten");

endmodule
